// ===== rtl/core/lir_pkg.sv =====
// Shared types and constants for the linear interpolation resampler.
`timescale 1ns / 1ps
package lir_pkg;

  localparam int unsigned SAMPLE_W  = 16;
  localparam int unsigned STEP_W    = 19;
  localparam int unsigned GAIN_W    = 15;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DAT_W = 19;
  // diff * gain and base * gain product widths
  localparam int unsigned DG_W      = 32;
  localparam int unsigned BG_W      = 31;

  localparam logic [CFG_IDX_W-1:0] REG_PHASE_STEP = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN       = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MONO       = 2'd2;

  localparam logic [SAMPLE_W-1:0] SAT_MAX = 16'h7fff;
  localparam logic [SAMPLE_W-1:0] SAT_MIN = 16'h8000;

  localparam logic [STEP_W-1:0] STEP_RESET = 19'd65536;
  localparam logic [GAIN_W-1:0] GAIN_RESET = 15'd13107;

  typedef enum logic [2:0] {
    MUL_NONE,
    MUL_BGL,
    MUL_BGR,
    MUL_DGL,
    MUL_DGR,
    MUL_OUTL,
    MUL_OUTR
  } mul_op_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_BGL,
    S_BGR,
    S_DGL,
    S_DGR,
    S_CHK,
    S_OUTL,
    S_OUTR,
    S_FIN
  } seq_state_e;

  typedef struct packed {
    mul_op_e op;
    logic    load_out;
    logic    last;
    logic    bypass;
  } seq_ctrl_t;

endpackage

// ===== rtl/core/lir_mul.sv =====
// Shared signed multiplier with registered product.
`timescale 1ns / 1ps
module lir_mul #(
  parameter int unsigned AW = 32,
  parameter int unsigned BW = 17
) (
  input  logic                 clk_i,
  input  logic                 en_i,
  input  logic signed [AW-1:0] a_i,
  input  logic signed [BW-1:0] b_i,
  output logic signed [AW+BW-1:0] p_o
);

  logic signed [AW+BW-1:0] p_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_q <= (AW+BW)'(a_i) * (AW+BW)'(b_i);
    end
  end

  assign p_o = p_q;

endmodule

// ===== rtl/core/lir_seq.sv =====
// Sequencer: phase accumulator, output count and multiplier schedule.
`timescale 1ns / 1ps
module lir_seq
  import lir_pkg::*;
#(
  parameter int unsigned PHASE_FRAC_BITS = 16,
  parameter int unsigned MAX_OUTPUTS     = 16
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_accept_i,
  input  logic                       start_i,
  input  logic [STEP_W-1:0]          phase_step_i,
  input  logic                       out_free_i,
  output logic                       in_ready_o,
  output logic [PHASE_FRAC_BITS-1:0] frac_o,
  output seq_ctrl_t                  ctrl_o
);

  localparam int unsigned PhaseW = ((PHASE_FRAC_BITS > STEP_W) ? PHASE_FRAC_BITS : STEP_W) + 1;
  localparam int unsigned CntW   = (MAX_OUTPUTS > 1) ? $clog2(MAX_OUTPUTS) : 1;
  localparam logic [PhaseW-1:0] PhaseOne = PhaseW'(1) << PHASE_FRAC_BITS;

  seq_state_e        state_q, state_d;
  logic [PhaseW-1:0] phase_q, phase_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic [PhaseW-1:0] step_ext;
  logic [PhaseW:0]   phase_sum;
  logic              bypass;
  logic              last;

  assign step_ext  = PhaseW'(phase_step_i);
  assign bypass    = (step_ext == PhaseOne);
  assign phase_sum = {1'b0, phase_q} + {1'b0, step_ext};
  assign last      = bypass || (cnt_q == CntW'(MAX_OUTPUTS - 1)) ||
                     (phase_sum >= {1'b0, PhaseOne});
  assign frac_o    = bypass ? '0 : phase_q[PHASE_FRAC_BITS-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      phase_q <= '0;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
    end
  end

  always_comb begin
    state_d         = state_q;
    phase_d         = phase_q;
    cnt_d           = cnt_q;
    in_ready_o      = 1'b0;
    ctrl_o.op       = MUL_NONE;
    ctrl_o.load_out = 1'b0;
    ctrl_o.last     = last;
    ctrl_o.bypass   = bypass;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_accept_i) begin
          if (start_i) begin
            phase_d = '0;
          end else if (phase_q >= PhaseOne) begin
            phase_d = phase_q - PhaseOne;
          end
          state_d = S_BGL;
        end
      end
      S_BGL: begin
        ctrl_o.op = MUL_BGL;
        state_d   = S_BGR;
      end
      S_BGR: begin
        ctrl_o.op = MUL_BGR;
        state_d   = S_DGL;
      end
      S_DGL: begin
        ctrl_o.op = MUL_DGL;
        state_d   = S_DGR;
      end
      S_DGR: begin
        ctrl_o.op = MUL_DGR;
        state_d   = S_CHK;
      end
      S_CHK: begin
        cnt_d = '0;
        if (bypass || (phase_q < PhaseOne)) begin
          state_d = S_OUTL;
        end else begin
          state_d = S_IDLE;
        end
      end
      S_OUTL: begin
        ctrl_o.op = MUL_OUTL;
        state_d   = S_OUTR;
      end
      S_OUTR: begin
        ctrl_o.op = MUL_OUTR;
        state_d   = S_FIN;
      end
      S_FIN: begin
        if (out_free_i) begin
          ctrl_o.load_out = 1'b1;
          cnt_d           = cnt_q + CntW'(1);
          if (!bypass) begin
            phase_d = phase_sum[PhaseW-1:0];
          end
          state_d = last ? S_IDLE : S_OUTL;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // outside bypass, an emitted sample always sits inside the current source interval
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl_o.load_out && !bypass) |-> (phase_q < PhaseOne))
    else $error("phase out of interval at emission");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FIN) |-> (cnt_q <= CntW'(MAX_OUTPUTS - 1)))
    else $error("output count overrun");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl_o.load_out && last) |=> (state_q == S_IDLE))
    else $error("run did not end after last item");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept_i |=> (state_q == S_BGL))
    else $error("accepted item not started");

endmodule

// ===== rtl/core/linear_interp_audio_resampler.sv =====
// Top level: linear interpolation resampler with gain and saturation.
//
// Source frames enter on the s_axis channel (tdata = left, right; tuser =
// start of sound). Output frames leave on m_axis (tdata = left, right;
// tlast on the final frame caused by one source frame). Registers are
// written over the cfg channel, which is always ready: index 0 phase step
// (Q16 source/output ratio, 1.0 = bypass), 1 gain (Q1.14), 2 mono source.
//
// Each source frame is handled by one multiplier reused under a sequencer:
// four set-up products (base and slope times gain, per channel), then two
// products per output frame. The sequencer walks BGL, BGR, DGL, DGR and CHK,
// then OUTL, OUTR and FIN per output frame; s_axis_tready is high only
// between items. The first output is loaded into the output register in FIN.
// A frame that falls entirely between output instants gives no output.
//
// Reset clears phase, history and output valid; registers go to
// step 1.0, gain 0.8, stereo. When m_axis stalls the result waits in the
// output register and the sequencer holds until it is taken.
`timescale 1ns / 1ps
module linear_interp_audio_resampler
  import lir_pkg::*;
#(
  parameter int unsigned PHASE_FRAC_BITS = 16,
  parameter int unsigned GAIN_FRAC_BITS  = 14,
  parameter int unsigned MAX_OUTPUTS     = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [31:0]          s_axis_tdata,  // source_left, source_right
  input  logic                 s_axis_tuser,  // start_of_sound
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [31:0]          m_axis_tdata,  // out_left, out_right
  output logic                 m_axis_tlast,  // last_of_run
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CFG_DAT_W-1:0] cfg_data_i
);

  localparam int unsigned AW    = DG_W;
  localparam int unsigned BW    = ((PHASE_FRAC_BITS > GAIN_W) ? PHASE_FRAC_BITS : GAIN_W) + 1;
  localparam int unsigned PW    = AW + BW;
  localparam int unsigned AccW  = BG_W + 2 + PHASE_FRAC_BITS;
  localparam int unsigned Shift = PHASE_FRAC_BITS + GAIN_FRAC_BITS;
  localparam int unsigned QW    = AccW - Shift;
  localparam logic [AccW-1:0] RoundBias = (AccW'(1) << Shift) - AccW'(1);

  logic [STEP_W-1:0] step_q;
  logic [GAIN_W-1:0] gain_q;
  logic              mono_q;

  logic                       in_accept;
  logic                       out_free;
  logic [PHASE_FRAC_BITS-1:0] frac;
  seq_ctrl_t                  ctrl;
  mul_op_e                    prev_op_q;

  logic                       have_q;
  logic signed [SAMPLE_W-1:0] new_l, new_r;
  logic signed [SAMPLE_W-1:0] prev_l_q, prev_r_q, cur_l_q, cur_r_q;
  logic signed [SAMPLE_W-1:0] base_l, base_r;
  logic signed [SAMPLE_W:0]   diff_l, diff_r;
  logic signed [BG_W-1:0]     bg_l_q, bg_r_q, bg_sel;
  logic signed [DG_W-1:0]     dg_l_q, dg_r_q;

  logic signed [AW-1:0]       mul_a;
  logic signed [BW-1:0]       mul_b;
  logic signed [BW-1:0]       gain_b, frac_b;
  logic signed [PW-1:0]       prod;

  logic signed [AccW-1:0]     acc, acc_adj;
  logic signed [QW-1:0]       quo;
  logic [SAMPLE_W-1:0]        sat;
  logic [SAMPLE_W-1:0]        res_l_q;

  logic                       out_valid_q, out_last_q;
  logic [SAMPLE_W-1:0]        out_l_q, out_r_q;

  assign in_accept   = s_axis_tvalid && s_axis_tready;
  assign out_free    = !out_valid_q || m_axis_tready;
  assign cfg_ready_o = 1'b1;

  // configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= STEP_RESET;
      gain_q <= GAIN_RESET;
      mono_q <= 1'b0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_PHASE_STEP: step_q <= cfg_data_i[STEP_W-1:0];
        REG_GAIN:       gain_q <= cfg_data_i[GAIN_W-1:0];
        REG_MONO:       mono_q <= cfg_data_i[0];
        default:        ;
      endcase
    end
  end

  lir_seq #(
    .PHASE_FRAC_BITS(PHASE_FRAC_BITS),
    .MAX_OUTPUTS    (MAX_OUTPUTS)
  ) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_accept_i (in_accept),
    .start_i     (s_axis_tuser),
    .phase_step_i(step_q),
    .out_free_i  (out_free),
    .in_ready_o  (s_axis_tready),
    .frac_o      (frac),
    .ctrl_o      (ctrl)
  );

  // two-frame window
  assign new_l = signed'(s_axis_tdata[15:0]);
  assign new_r = mono_q ? new_l : signed'(s_axis_tdata[31:16]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      have_q    <= 1'b0;
      prev_op_q <= MUL_NONE;
    end else begin
      prev_op_q <= ctrl.op;
      if (in_accept) begin
        have_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      if (have_q && !s_axis_tuser) begin
        prev_l_q <= cur_l_q;
        prev_r_q <= cur_r_q;
      end else begin
        prev_l_q <= new_l;
        prev_r_q <= new_r;
      end
      cur_l_q <= new_l;
      cur_r_q <= new_r;
    end
  end

  assign base_l = ctrl.bypass ? cur_l_q : prev_l_q;
  assign base_r = ctrl.bypass ? cur_r_q : prev_r_q;
  assign diff_l = (SAMPLE_W+1)'(cur_l_q) - (SAMPLE_W+1)'(base_l);
  assign diff_r = (SAMPLE_W+1)'(cur_r_q) - (SAMPLE_W+1)'(base_r);

  // operand select for the shared multiplier
  assign gain_b = signed'(BW'(gain_q));
  assign frac_b = signed'(BW'(frac));

  always_comb begin
    case (ctrl.op)
      MUL_BGL: begin
        mul_a = AW'(base_l);
        mul_b = gain_b;
      end
      MUL_BGR: begin
        mul_a = AW'(base_r);
        mul_b = gain_b;
      end
      MUL_DGL: begin
        mul_a = AW'(diff_l);
        mul_b = gain_b;
      end
      MUL_DGR: begin
        mul_a = AW'(diff_r);
        mul_b = gain_b;
      end
      MUL_OUTL: begin
        mul_a = dg_l_q;
        mul_b = frac_b;
      end
      MUL_OUTR: begin
        mul_a = dg_r_q;
        mul_b = frac_b;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  lir_mul #(
    .AW(AW),
    .BW(BW)
  ) u_mul (
    .clk_i(clk_i),
    .en_i (ctrl.op != MUL_NONE),
    .a_i  (mul_a),
    .b_i  (mul_b),
    .p_o  (prod)
  );

  // accumulate, truncate toward zero, saturate
  assign bg_sel  = (prev_op_q == MUL_OUTL) ? bg_l_q : bg_r_q;
  assign acc     = (AccW'(bg_sel) <<< PHASE_FRAC_BITS) + signed'(prod[AccW-1:0]);
  assign acc_adj = acc[AccW-1] ? (acc + signed'(RoundBias)) : acc;
  assign quo     = signed'(acc_adj[AccW-1:Shift]);

  always_comb begin
    if ((&quo[QW-1:SAMPLE_W-1]) || !(|quo[QW-1:SAMPLE_W-1])) begin
      sat = quo[SAMPLE_W-1:0];
    end else if (quo[QW-1]) begin
      sat = SAT_MIN;
    end else begin
      sat = SAT_MAX;
    end
  end

  always_ff @(posedge clk_i) begin
    case (prev_op_q)
      MUL_BGL:  bg_l_q  <= signed'(prod[BG_W-1:0]);
      MUL_BGR:  bg_r_q  <= signed'(prod[BG_W-1:0]);
      MUL_DGL:  dg_l_q  <= signed'(prod[DG_W-1:0]);
      MUL_DGR:  dg_r_q  <= signed'(prod[DG_W-1:0]);
      MUL_OUTL: res_l_q <= sat;
      default:  ;
    endcase
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctrl.load_out) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl.load_out) begin
      out_l_q    <= res_l_q;
      out_r_q    <= sat;
      out_last_q <= ctrl.last;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_r_q, out_l_q};
  assign m_axis_tlast  = out_last_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.load_out |-> out_free)
    else $error("output register overwritten");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (prev_op_q == MUL_OUTL) |-> (ctrl.op == MUL_OUTR))
    else $error("right product not following left");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=>
      (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast)))
    else $error("output item changed while stalled");

endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for the linear interpolation audio resampler.
`timescale 1ns / 1ps
module tb
  import lir_pkg::*;
();

  localparam logic [19:0] PHASE_ONE     = 20'h10000;
  localparam int          FRAC_SHIFT    = 30;
  localparam int          MAX_OUTPUTS   = 16;
  localparam int          SETTLE_CYCLES = 64;
  localparam int          HOLD_CYCLES   = 400;
  localparam int          CYCLE_LIMIT   = 500000;

  typedef struct {
    logic [15:0] left;
    logic [15:0] right;
    logic        last;
  } out_frame_t;

  logic                 clk_i         = 1'b0;
  logic                 rst_ni        = 1'b0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [31:0]          s_axis_tdata  = '0;
  logic                 s_axis_tuser  = 1'b0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [31:0]          m_axis_tdata;
  logic                 m_axis_tlast;
  logic                 cfg_valid_i   = 1'b0;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i   = REG_PHASE_STEP;
  logic [CFG_DAT_W-1:0] cfg_data_i    = '0;

  // predictor state and register copy
  logic [STEP_W-1:0]   step_m     = STEP_RESET;
  logic [GAIN_W-1:0]   gain_m     = GAIN_RESET;
  logic                mono_m     = 1'b0;
  logic [19:0]         phase_m    = '0;
  logic signed [15:0]  prev_l_m   = '0;
  logic signed [15:0]  prev_r_m   = '0;
  logic signed [15:0]  cur_l_m    = '0;
  logic signed [15:0]  cur_r_m    = '0;
  logic                have_cur_m = 1'b0;

  out_frame_t  pending_outputs[$];
  int unsigned mismatches    = 0;
  int unsigned src_idle_pct  = 0;
  int unsigned snk_stall_pct = 0;
  int unsigned cycle_cnt     = 0;
  logic        sink_hold     = 1'b0;
  event        hold_ev;

  linear_interp_audio_resampler dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // (base + frac * (target - base)) * gain, truncated toward zero, saturated
  function automatic logic [15:0] gained_sample(logic signed [15:0] base,
                                                logic signed [15:0] target,
                                                logic [15:0] frac);
    longint acc;
    longint q;
    acc = longint'(base) * longint'(PHASE_ONE)
        + longint'(frac) * (longint'(target) - longint'(base));
    acc = acc * longint'(gain_m);
    q = (acc < 0) ? -((-acc) >> FRAC_SHIFT) : (acc >> FRAC_SHIFT);
    if (q > 32767) q = 32767;
    else if (q < -32768) q = -32768;
    return q[15:0];
  endfunction

  function automatic void resample_frame(logic signed [15:0] l_in,
                                         logic signed [15:0] r_in, logic sos);
    logic signed [15:0] r_eff;
    out_frame_t frm;
    int n;
    r_eff = mono_m ? l_in : r_in;
    n = 0;
    if (sos) begin
      phase_m    = '0;
      have_cur_m = 1'b0;
    end else if (phase_m >= PHASE_ONE) begin
      phase_m = phase_m - PHASE_ONE;
    end
    if (have_cur_m) begin
      prev_l_m = cur_l_m;
      prev_r_m = cur_r_m;
    end else begin
      prev_l_m = l_in;
      prev_r_m = r_eff;
    end
    cur_l_m    = l_in;
    cur_r_m    = r_eff;
    have_cur_m = 1'b1;
    if (step_m == PHASE_ONE) begin
      frm.left  = gained_sample(cur_l_m, cur_l_m, 16'd0);
      frm.right = gained_sample(cur_r_m, cur_r_m, 16'd0);
      frm.last  = 1'b1;
      pending_outputs.push_back(frm);
      return;
    end
    while (n < MAX_OUTPUTS && phase_m < PHASE_ONE) begin
      frm.left  = gained_sample(prev_l_m, cur_l_m, phase_m[15:0]);
      frm.right = gained_sample(prev_r_m, cur_r_m, phase_m[15:0]);
      phase_m   = phase_m + step_m;
      n++;
      frm.last  = (n == MAX_OUTPUTS) || (phase_m >= PHASE_ONE);
      pending_outputs.push_back(frm);
    end
  endfunction

  // output side: random stalls, optional long hold-off, result check
  always @(posedge clk_i) begin
    out_frame_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_outputs.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected output: L %0d R %0d last %0b",
                   $signed(m_axis_tdata[15:0]), $signed(m_axis_tdata[31:16]),
                   m_axis_tlast);
      end else begin
        want = pending_outputs.pop_front();
        if (m_axis_tdata[15:0] !== want.left || m_axis_tdata[31:16] !== want.right
            || m_axis_tlast !== want.last) begin
          mismatches++;
          if (mismatches <= 10)
            $display("output mismatch: expected L %0d R %0d last %0b, got L %0d R %0d last %0b",
                     $signed(want.left), $signed(want.right), want.last,
                     $signed(m_axis_tdata[15:0]), $signed(m_axis_tdata[31:16]),
                     m_axis_tlast);
        end
      end
    end
    m_axis_tready <= !sink_hold && ($urandom_range(99) >= snk_stall_pct);
  end

  initial begin
    forever begin
      @(hold_ev);
      sink_hold <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clk_i);
      sink_hold <= 1'b0;
    end
  end

  initial begin
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("== FAIL ==");
    $finish;
  end

  task automatic push_source_frame(input logic signed [15:0] l_in,
                                   input logic signed [15:0] r_in, input logic sos);
    if ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < src_idle_pct);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {r_in, l_in};
    s_axis_tuser  <= sos;
    do @(posedge clk_i); while (!s_axis_tready);
    resample_frame(l_in, r_in, sos);
  endtask

  task automatic wait_outputs_done();
    s_axis_tvalid <= 1'b0;
    while (pending_outputs.size() != 0) @(posedge clk_i);
  endtask

  // an item may still be in flight with no output owed, so let it finish
  task automatic drain_block();
    wait_outputs_done();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DAT_W-1:0] value);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      REG_PHASE_STEP: step_m = value[STEP_W-1:0];
      REG_GAIN:       gain_m = value[GAIN_W-1:0];
      REG_MONO:       mono_m = value[0];
      default: ;
    endcase
  endtask

  task automatic set_config(input logic [STEP_W-1:0] step,
                            input logic [GAIN_W-1:0] gain, input logic mono);
    drain_block();
    write_reg(REG_PHASE_STEP, CFG_DAT_W'(step));
    write_reg(REG_GAIN, CFG_DAT_W'(gain));
    write_reg(REG_MONO, CFG_DAT_W'(mono));
    cfg_valid_i <= 1'b0;
  endtask

  function automatic logic signed [15:0] rand_sample();
    case ($urandom_range(7))
      0:       return 16'sh7fff;
      1:       return 16'sh8000;
      default: return 16'($urandom());
    endcase
  endfunction

  function automatic logic [STEP_W-1:0] rand_step();
    case ($urandom_range(7))
      0:       return STEP_RESET;
      1:       return STEP_W'($urandom_range(4096, 16384));
      2, 3:    return STEP_W'($urandom_range(16384, 65535));
      4:       return STEP_W'($urandom_range(65537, 131072));
      5:       return STEP_W'($urandom_range(131072, 262144));
      6:       return STEP_W'($urandom_range(4096, 262144));
      default: begin
        case ($urandom_range(3))
          0:       return '0;
          1:       return '1;
          2:       return STEP_W'(4096);
          default: return STEP_W'(262144);
        endcase
      end
    endcase
  endfunction

  function automatic logic [GAIN_W-1:0] rand_gain();
    case ($urandom_range(5))
      0:       return '0;
      1:       return '1;
      default: return GAIN_W'($urandom());
    endcase
  endfunction

  task automatic test_reset_defaults();
    push_source_frame(16'sh7fff, 16'sh8000, 1'b1);
    push_source_frame(16'sh8000, 16'sh7fff, 1'b0);
    push_source_frame(16'sd0, -16'sd1, 1'b0);
    push_source_frame(16'sd1, 16'sd0, 1'b0);
  endtask

  task automatic test_bypass_gain_extremes();
    set_config(STEP_RESET, '1, 1'b0);
    push_source_frame(16'sh7fff, 16'sh8000, 1'b0);
    push_source_frame(-16'sd20000, 16'sd20000, 1'b0);
    set_config(STEP_RESET, '0, 1'b1);
    push_source_frame(16'sd12345, -16'sd5, 1'b0);
  endtask

  task automatic test_interpolation_cases();
    // sixteen outputs per item over a full-scale swing
    set_config(STEP_W'(4096), GAIN_W'(16384), 1'b0);
    push_source_frame(16'sh8000, 16'sh7fff, 1'b1);
    push_source_frame(16'sh7fff, 16'sh8000, 1'b0);
    // zero step: output count capped
    set_config('0, '1, 1'b0);
    push_source_frame(16'sd1000, -16'sd1000, 1'b0);
    // downsampling: most frames give nothing
    set_config(STEP_W'(262144), GAIN_W'(16384), 1'b0);
    push_source_frame(16'sd100, 16'sd200, 1'b1);
    push_source_frame(16'sd300, 16'sd400, 1'b0);
    push_source_frame(16'sd500, 16'sd600, 1'b0);
    push_source_frame(16'sd700, 16'sd800, 1'b0);
    push_source_frame(16'sd900, 16'sd1000, 1'b0);
    set_config('1, GAIN_W'(20000), 1'b0);
    push_source_frame(16'sh7fff, 16'sh7fff, 1'b1);
    push_source_frame(16'sd0, 16'sd0, 1'b0);
    push_source_frame(16'sd5, 16'sd5, 1'b0);
    // mono copy, new sound mid-stream
    set_config(STEP_W'(98304), GAIN_W'(16384), 1'b1);
    push_source_frame(16'sd1000, 16'sh8000, 1'b1);
    push_source_frame(-16'sd1000, 16'sh7fff, 1'b0);
    push_source_frame(16'sd2000, 16'sd0, 1'b1);
  endtask

  task automatic test_random_traffic(input int unsigned idle_pct,
                                     input int unsigned stall_pct);
    src_idle_pct  = idle_pct;
    snk_stall_pct = stall_pct;
    repeat (3) begin
      set_config(rand_step(), rand_gain(), 1'($urandom_range(1)));
      push_source_frame(rand_sample(), rand_sample(), 1'b1);
      repeat (17)
        push_source_frame(rand_sample(), rand_sample(), ($urandom_range(11) == 0));
    end
  endtask

  task automatic test_backpressure();
    src_idle_pct  = 0;
    snk_stall_pct = 0;
    set_config(STEP_W'(4096), GAIN_W'(16384), 1'b0);
    -> hold_ev;
    push_source_frame(rand_sample(), rand_sample(), 1'b1);
    repeat (11) push_source_frame(rand_sample(), rand_sample(), 1'b0);
    wait_outputs_done();
    repeat (6) push_source_frame(rand_sample(), rand_sample(), 1'b0);
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_reset_defaults();
    test_bypass_gain_extremes();
    test_interpolation_cases();
    test_random_traffic(0, 0);
    test_random_traffic(76, 0);
    test_random_traffic(0, 76);
    test_random_traffic(16, 16);
    test_backpressure();
    drain_block();
    if (mismatches == 0 && pending_outputs.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/lir_pkg.sv
rtl/core/lir_mul.sv
rtl/core/lir_seq.sv
rtl/core/linear_interp_audio_resampler.sv
tb/tb.sv
